// File: src/css_pkg.sv
// Package with shared types, character codes and the per-byte classifier function.
package css_pkg;

  // Character codes that steer the filter.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_BLOCK = 2'd1,
    MODE_LINE  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_SLASH = 2'd1,
    PEND_BSL   = 2'd2,
    PEND_STAR  = 2'd3
  } pend_t;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_BREAK  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Scanner state carried from byte to byte.
  typedef struct packed {
    mode_t  cm;
    quote_t oq;
    logic   lwb;
    pend_t  pend;
  } state_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       qerr;
    logic       cerr;
  } rec_t;

  // The results of one input byte, as they wait in the queue.
  typedef struct packed {
    logic two;
    rec_t r0;
    rec_t r1;
  } group_t;

  // Outcome of handling a byte with nothing pending.
  typedef struct packed {
    state_t st;
    logic   emit;
    rec_t   rec;
  } step_t;

  localparam state_t STATE_RESET = '{cm: MODE_NONE, oq: Q_NONE, lwb: 1'b0,
                                     pend: PEND_NONE};

  function automatic rec_t text_rec(logic [7:0] c);
    rec_t r;
    r = '{data: c, kind: KIND_TEXT, qerr: 1'b0, cerr: 1'b0};
    return r;
  endfunction

  // Handle one byte with no lookahead pending.
  function automatic step_t plain_byte(state_t s, logic [7:0] c);
    step_t  r;
    quote_t q;
    r.st   = s;
    r.emit = 1'b0;
    r.rec  = text_rec(c);
    q      = (c == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
    if (c == CH_CR) begin
      r.emit = 1'b0;
    end else if (c == CH_LF) begin
      r.st.oq = Q_NONE;
      r.emit  = 1'b1;
      if (s.cm == MODE_BLOCK) begin
        r.rec = '{data: 8'h00, kind: KIND_BREAK, qerr: 1'b0, cerr: 1'b0};
      end else begin
        r.st.cm  = MODE_NONE;
        r.st.lwb = 1'b0;
      end
    end else if (c == CH_BSL) begin
      r.st.pend = PEND_BSL;
    end else if (s.cm == MODE_BLOCK) begin
      if (c == CH_STAR) begin
        r.st.pend = PEND_STAR;
      end
    end else if (s.cm == MODE_LINE) begin
      r.emit = 1'b0;
    end else if (c inside {CH_SQ, CH_DQ}) begin
      if (s.oq == Q_NONE) begin
        r.st.oq = q;
      end else if (!s.lwb && s.oq == q) begin
        r.st.oq = Q_NONE;
      end
      r.emit   = 1'b1;
      r.st.lwb = 1'b0;
    end else if (c == CH_SLASH && s.oq == Q_NONE) begin
      r.st.pend = PEND_SLASH;
    end else begin
      r.emit   = 1'b1;
      r.st.lwb = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: src/css_front.sv
// Front end: holds the scanner state and turns each accepted byte into a result group.
module css_front import css_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       has_result,
  output group_t     grp
);

  state_t state;
  state_t state_next;
  state_t base;
  step_t  p;
  logic   lead;
  rec_t   lead_rec;
  logic   do_plain;
  rec_t   stat_rec;

  // Scanner state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Resolve the pending lookahead first, then run the plain byte handler once.
  always_comb begin
    base       = state;
    base.pend  = PEND_NONE;
    lead       = 1'b0;
    lead_rec   = text_rec(CH_SLASH);
    do_plain   = 1'b0;
    case (state.pend)
      PEND_BSL: begin
        if (in_byte == CH_CR) begin
          base.pend = PEND_BSL;
        end else if (in_byte == CH_LF) begin
          lead     = 1'b1;
          lead_rec = '{data: 8'h00, kind: KIND_BREAK, qerr: 1'b0, cerr: 1'b0};
        end else begin
          do_plain = 1'b1;
          if (state.cm == MODE_NONE) begin
            lead     = 1'b1;
            lead_rec = text_rec(CH_BSL);
            base.lwb = 1'b1;
          end
        end
      end
      PEND_SLASH: begin
        if (in_byte == CH_STAR) begin
          base.cm = MODE_BLOCK;
        end else if (in_byte == CH_SLASH) begin
          base.cm = MODE_LINE;
        end else begin
          lead     = 1'b1;
          base.lwb = 1'b0;
          do_plain = (in_byte != CH_CR);
        end
      end
      PEND_STAR: begin
        if (in_byte == CH_SLASH) begin
          base.cm = MODE_NONE;
        end else begin
          do_plain = (in_byte != CH_CR);
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
  end

  assign p = plain_byte(base, in_byte);

  // End-of-file status beat.
  always_comb begin
    stat_rec = '{data: 8'h00, kind: KIND_STATUS, qerr: (state.oq != Q_NONE),
                 cerr: (state.cm == MODE_BLOCK)};
  end

  // Assemble the group and the next state.
  always_comb begin
    grp        = '{two: 1'b0, r0: stat_rec, r1: stat_rec};
    has_result = 1'b0;
    state_next = base;
    if (end_of_input) begin
      state_next = STATE_RESET;
      has_result = 1'b1;
      if (state.pend == PEND_SLASH) begin
        grp.two = 1'b1;
        grp.r0  = text_rec(CH_SLASH);
      end else if (state.pend == PEND_BSL && state.cm == MODE_NONE) begin
        grp.two = 1'b1;
        grp.r0  = text_rec(CH_BSL);
      end
    end else begin
      if (do_plain) begin
        state_next = p.st;
      end
      if (lead) begin
        has_result = 1'b1;
        grp.r0     = lead_rec;
        grp.two    = do_plain && p.emit;
        grp.r1     = p.rec;
      end else if (do_plain && p.emit) begin
        has_result = 1'b1;
        grp.r0     = p.rec;
      end
    end
  end

endmodule

// File: src/css_fifo.sv
// Short register queue of result groups between the front and back ends.
module css_fifo import css_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  group_t wr_grp,
  input  logic   rd,
  output logic   full,
  output logic   valid,
  output group_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_grp;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (!full || rd)) else $error("write into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> valid) else $error("read from an empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == $past(count) + 1'b1) else $error("count did not rise");

endmodule

// File: src/css_back.sv
// Back end: delivers the beats of the head group one at a time.
module css_back import css_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  group_t head,
  input  logic   pop,
  output logic   q_pop,
  output logic   empty,
  output rec_t   rec,
  output logic   last
);

  logic sub;
  logic take;

  assign empty = !q_valid;
  assign take  = pop && q_valid;
  assign rec   = sub ? head.r1 : head.r0;
  assign last  = sub || !head.two;
  assign q_pop = take && last;

  // Second-beat marker for two-beat groups.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (take) begin
      sub <= !last;
    end
  end

  a_sub_two: assert property (@(posedge clk) disable iff (rst)
    sub |-> (q_valid && head.two)) else $error("second beat without a two-beat group");
  a_sub_clears: assert property (@(posedge clk) disable iff (rst)
    (sub && take) |=> !sub) else $error("second beat not retired");
  a_first_to_second: assert property (@(posedge clk) disable iff (rst)
    (!sub && take && head.two) |=> sub) else $error("second beat skipped");

endmodule

// File: src/comment_and_splice_stripper_top.sv
// Top level of the comment and splice stripper.
// The block takes one source byte per clock when full is low and emits zero, one or two
// result beats for it: kept text, hidden line-break marks for swallowed newlines, and one
// status beat at end of input. The front end classifies each byte in the cycle it is
// accepted and writes its beats as one group into a DEPTH-entry register queue; the
// group reaches the output ports once every group ahead of it is popped. The back end drains
// one beat per clock while pop is high, so a byte that yields two beats comes out as two
// beats, and full rises only once DEPTH groups are waiting. last_of_run marks the final beat
// of each byte. There is no start-up delay after reset. DEPTH must be at least 2.
module comment_and_splice_stripper_top import css_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       open_quote_error,
  output logic       open_comment_error,
  output logic       last_of_run
);

  logic   accept;
  logic   has_result;
  group_t grp;
  logic   q_valid;
  group_t head;
  logic   q_pop;
  rec_t   rec;

  assign accept = push && !full;

  // Classifier and scanner state.
  css_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .has_result   (has_result),
    .grp          (grp)
  );

  // Group queue.
  css_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept && has_result),
    .wr_grp (grp),
    .rd     (q_pop),
    .full   (full),
    .valid  (q_valid),
    .head   (head)
  );

  // Beat sequencer.
  css_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .q_pop   (q_pop),
    .empty   (empty),
    .rec     (rec),
    .last    (last_of_run)
  );

  assign out_byte           = rec.data;
  assign kind               = rec.kind;
  assign open_quote_error   = rec.qerr;
  assign open_comment_error = rec.cerr;

endmodule

// File: bench/comment_and_splice_stripper_top_tb.sv
// Self-checking bench for the comment and splice stripper: directed and random source text.
module comment_and_splice_stripper_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import css_pkg::*;

  // One expected result beat.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       qerr;
    logic       cerr;
    logic       last;
  } beat_t;

  // One input beat for the stimulus list.
  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
  } item_t;

  // Tracks the scanner state and holds the beats that should come out, in order.
  class strip_scoreboard;
    mode_t  cmode;
    quote_t qopen;
    bit     prev_bsl;
    pend_t  held;
    beat_t  run[$];
    beat_t  awaited[$];
    int     errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      cmode    = MODE_NONE;
      qopen    = Q_NONE;
      prev_bsl = 1'b0;
      held     = PEND_NONE;
    endfunction

    function int count();
      return awaited.size();
    endfunction

    function void put(logic [7:0] data, kind_t k, logic qe, logic ce);
      beat_t b;
      b.data = data;
      b.kind = k;
      b.qerr = qe;
      b.cerr = ce;
      b.last = 1'b0;
      run.push_back(b);
    endfunction

    function void put_text(logic [7:0] c);
      prev_bsl = (c == CH_BSL);
      put(c, KIND_TEXT, 1'b0, 1'b0);
    endfunction

    // A byte that arrives with no lookahead held.
    function void plain(logic [7:0] c);
      quote_t q;
      if (c == CH_CR) return;
      if (c == CH_LF) begin
        qopen = Q_NONE;
        if (cmode == MODE_BLOCK) begin
          put(8'h00, KIND_BREAK, 1'b0, 1'b0);
          return;
        end
        cmode = MODE_NONE;
        put_text(c);
        return;
      end
      if (c == CH_BSL) begin
        held = PEND_BSL;
        return;
      end
      if (cmode == MODE_BLOCK) begin
        if (c == CH_STAR) held = PEND_STAR;
        return;
      end
      if (cmode == MODE_LINE) return;
      if (c == CH_SQ || c == CH_DQ) begin
        q = (c == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
        if (qopen == Q_NONE) qopen = q;
        else if (!prev_bsl && qopen == q) qopen = Q_NONE;
        put_text(c);
        return;
      end
      if (c == CH_SLASH && qopen == Q_NONE) begin
        held = PEND_SLASH;
        return;
      end
      put_text(c);
    endfunction

    // Works out the beats that one accepted input causes.
    function void note_input(logic [7:0] c, logic eoi);
      pend_t was;
      beat_t b;
      was = held;
      run.delete();
      if (eoi) begin
        // End of file flushes what is held, then reports the open state.
        if (was == PEND_SLASH) put_text(CH_SLASH);
        else if (was == PEND_BSL && cmode == MODE_NONE) put_text(CH_BSL);
        put(8'h00, KIND_STATUS, qopen != Q_NONE, cmode == MODE_BLOCK);
        clear_state();
      end else begin
        held = PEND_NONE;
        case (was)
          PEND_BSL: begin
            if (c == CH_CR) begin
              held = PEND_BSL;
            end else if (c == CH_LF) begin
              put(8'h00, KIND_BREAK, 1'b0, 1'b0);
            end else begin
              if (cmode == MODE_NONE) put_text(CH_BSL);
              plain(c);
            end
          end
          PEND_SLASH: begin
            if (c == CH_STAR) begin
              cmode = MODE_BLOCK;
            end else if (c == CH_SLASH) begin
              cmode = MODE_LINE;
            end else begin
              put_text(CH_SLASH);
              if (c != CH_CR) plain(c);
            end
          end
          PEND_STAR: begin
            if (c == CH_SLASH) cmode = MODE_NONE;
            else if (c != CH_CR) plain(c);
          end
          default: plain(c);
        endcase
      end
      if (run.size() > 0) begin
        b = run.pop_back();
        b.last = 1'b1;
        run.push_back(b);
      end
      foreach (run[k]) awaited.push_back(run[k]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_beat(logic [7:0] data, logic [1:0] k, logic qe, logic ce,
                             logic last);
      beat_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data=%h kind=%0d",
                 $time, data, k);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("out_byte", want.data, data);
      compare_field("kind", 8'(want.kind), 8'(k));
      compare_field("open_quote_error", 8'(want.qerr), 8'(qe));
      compare_field("open_comment_error", 8'(want.cerr), 8'(ce));
      compare_field("last_of_run", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       open_quote_error;
  logic       open_comment_error;
  logic       last_of_run;

  strip_scoreboard sb;
  item_t           stim[$];
  int              tx_idle;
  int              rx_idle;

  comment_and_splice_stripper_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .end_of_input       (end_of_input),
    .pop                (pop),
    .empty              (empty),
    .out_byte           (out_byte),
    .kind               (kind),
    .open_quote_error   (open_quote_error),
    .open_comment_error (open_comment_error),
    .last_of_run        (last_of_run)
  );

  always #5 clk = ~clk;

  // Hard stop if the run hangs.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function void add(logic [7:0] c);
    stim.push_back('{c: c, eoi: 1'b0});
  endfunction

  function void add_end();
    stim.push_back('{c: 8'($urandom_range(0, 255)), eoi: 1'b1});
  endfunction

  function logic [7:0] letter();
    if ($urandom_range(0, 5) == 0) return " ";
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function logic [7:0] special_char();
    case ($urandom_range(0, 6))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_BSL;
      3: return CH_SLASH;
      4: return CH_STAR;
      5: return CH_DQ;
      default: return CH_SQ;
    endcase
  endfunction

  // Content of comments: mostly letters, with a fair share of the steering characters.
  function logic [7:0] inner_char();
    if ($urandom_range(0, 9) < 4) return special_char();
    return letter();
  endfunction

  // Appends one random fragment of source text.
  function void gen_snippet();
    int         sel;
    int         n;
    logic [7:0] q;
    sel = $urandom_range(0, 99);
    n   = $urandom_range(0, 6);
    if (sel < 20) begin
      repeat (n + 1) add(letter());
    end else if (sel < 33) begin
      add(CH_SLASH);
      add(CH_STAR);
      repeat (n) add(inner_char());
      add(CH_STAR);
      add(CH_SLASH);
    end else if (sel < 43) begin
      add(CH_SLASH);
      add(CH_SLASH);
      repeat (n) add(inner_char());
      add(CH_LF);
    end else if (sel < 58) begin
      q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
      add(q);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: begin add(CH_BSL); add(q); end
          1: add(CH_SLASH);
          2: add(special_char());
          default: add(letter());
        endcase
      end
      add(q);
    end else if (sel < 66) begin
      add(CH_BSL);
      if ($urandom_range(0, 1)) add(CH_CR);
      add(CH_LF);
    end else if (sel < 76) begin
      if ($urandom_range(0, 1)) add(CH_CR);
      add(CH_LF);
    end else if (sel < 86) begin
      repeat ((n % 4) + 1) add(8'($urandom_range(0, 255)));
    end else if (sel < 97) begin
      add(special_char());
    end else begin
      add_end();
    end
  endfunction

  // Short directed text that hits the corner cases first.
  function void build_directed();
    // Extreme byte, slash kept in a quote, quote held open by an escaping backslash.
    add(8'hFF); add(CH_DQ); add(CH_SLASH); add(CH_BSL); add(CH_DQ); add(CH_DQ);
    // Line comment survives a splice with a return in it; the null byte is dropped.
    add(CH_SLASH); add(CH_SLASH); add(CH_BSL); add(CH_CR); add(CH_LF); add(8'h00);
    add(CH_LF);
    // Return after a slash, then a block comment with a return after a star and
    // a newline inside, ended with a backslash held.
    add(CH_SLASH); add(CH_CR); add(CH_SLASH); add(CH_STAR); add(CH_STAR); add(CH_CR);
    add(CH_LF); add(CH_BSL); add_end();
    // Open quote at end with a held backslash flushed.
    add(CH_SQ); add(CH_BSL); add_end();
    // Held slash flushed at end.
    add(CH_SLASH); add_end();
  endfunction

  // Result side: pops at random, checks every accepted beat.
  task automatic drain_results();
    forever begin
      pop <= ($urandom_range(0, 99) >= rx_idle);
      @(posedge clk);
      if (pop && !empty)
        sb.check_beat(out_byte, kind, open_quote_error, open_comment_error, last_of_run);
    end
  endtask

  task automatic set_phase(int ph);
    case (ph)
      0: begin tx_idle = 35; rx_idle = 53; end
      1: begin tx_idle = 53; rx_idle = 35; end
      default: begin tx_idle = 0; rx_idle = 0; end
    endcase
  endtask

  // Input side: one beat per accepted push, with a full drain at each phase change.
  task automatic feed_stimulus();
    int i;
    int ph;
    int total;
    i     = 0;
    ph    = 0;
    total = stim.size();
    set_phase(0);
    while (i < total) begin
      if ((i * 3) / total != ph) begin
        push <= 1'b0;
        @(posedge clk);
        while (sb.count() != 0) @(posedge clk);
        ph = (i * 3) / total;
        set_phase(ph);
      end else if ($urandom_range(0, 99) < tx_idle) begin
        push <= 1'b0;
        @(posedge clk);
      end else begin
        push         <= 1'b1;
        in_byte      <= stim[i].c;
        end_of_input <= stim[i].eoi;
        @(posedge clk);
        if (!full) begin
          sb.note_input(stim[i].c, stim[i].eoi);
          i++;
        end
      end
    end
    push <= 1'b0;
  endtask

  initial begin
    sb = new();
    build_directed();
    while (stim.size() < 1275) gen_snippet();
    add_end();
    tx_idle = 0;
    rx_idle = 100;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none
    feed_stimulus();
    while (sb.count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/css_pkg.sv
src/css_front.sv
src/css_fifo.sv
src/css_back.sv
src/comment_and_splice_stripper_top.sv
bench/comment_and_splice_stripper_top_tb.sv
